// ----- src/gef_pkg.sv -----
// ----------------------------------------------------------------------------
// gef_pkg
// Shared types, number formats, weights and limits for the estimate fusion.
// ----------------------------------------------------------------------------
package gef_pkg;

    // distance format: signed, FRAC_BITS fraction bits
    localparam int DIST_W    = 24;
    localparam int FRAC_BITS = 16;
    localparam int Q16_W     = 16;
    localparam int RULE_W    = 4;

    // 1e-4 floor in distance lsbs, never below one lsb
    localparam int FLOOR_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int FLOOR_Q   = (FLOOR_RAW < 1) ? 1 : FLOOR_RAW;

    typedef logic signed [DIST_W-1:0] t_dist;
    typedef logic [Q16_W-1:0]         t_q16;
    typedef logic [RULE_W-1:0]        t_rule;

    localparam t_dist FLOOR_DIST = DIST_W'(FLOOR_Q);

    // blend weights, Q0.16, each pair sums to one
    localparam t_q16 W_58 = 16'd38011;
    localparam t_q16 W_42 = 16'd27525;
    localparam t_q16 W_72 = 16'd47186;
    localparam t_q16 W_28 = 16'd18350;
    localparam t_q16 W_62 = 16'd40632;
    localparam t_q16 W_38 = 16'd24904;
    localparam t_q16 W_54 = 16'd35389;
    localparam t_q16 W_46 = 16'd30147;

    // agreement limits, Q0.16
    localparam t_q16 GAP_36   = 16'd23593;
    localparam t_q16 RATIO_16 = 16'd10486;
    localparam t_q16 GAP_45   = 16'd29491;
    localparam t_q16 RATIO_18 = 16'd11796;
    localparam t_q16 GAP_42   = 16'd27525;
    localparam t_q16 GAP_55   = 16'd36045;
    localparam t_q16 RATIO_22 = 16'd14418;

    // rule codes
    localparam t_rule RULE_NONE       = 4'd0;
    localparam t_rule RULE_BOTH       = 4'd1;
    localparam t_rule RULE_FOOT_REG   = 4'd2;
    localparam t_rule RULE_SCALE_PRI  = 4'd3;
    localparam t_rule RULE_SCALE_FOOT = 4'd4;
    localparam t_rule RULE_SCALE_REG  = 4'd5;
    localparam t_rule RULE_PRI_FOOT   = 4'd6;
    localparam t_rule RULE_PRI_REG    = 4'd7;
    localparam t_rule RULE_PRI_GRD    = 4'd8;
    localparam t_rule RULE_LAST       = RULE_PRI_GRD;

    typedef struct packed {
        logic signed [DIST_W-1:0] foot_est;
        logic                     foot_ok;
        logic signed [DIST_W-1:0] grounded_est;
        logic                     grounded_ok;
        logic signed [DIST_W-1:0] region_est;
        logic                     region_ok;
        logic signed [DIST_W-1:0] scale_est;
        logic                     scale_ok;
        logic signed [DIST_W-1:0] prior_est;
        logic                     prior_ok;
        logic                     foot_region_agree;
    } t_in_item;

    typedef struct packed {
        logic signed [DIST_W-1:0] fused_ref;
        logic                     fused_ok;
        logic [RULE_W-1:0]        rule_taken;
    } t_out_item;

endpackage

// ----- src/gef_agree.sv -----
// ----------------------------------------------------------------------------
// gef_agree
// Three-stage agreement test: absolute gap and gap relative to the floored
// larger value, the ratio done by cross multiplication.
// ----------------------------------------------------------------------------
module gef_agree
    import gef_pkg::*;
(
    input  logic       i_clk,
    input  logic [2:0] i_en,
    input  t_dist      i_a,
    input  t_dist      i_b,
    input  t_q16       i_gap,
    input  t_q16       i_ratio,
    output logic       o_ok
);

    localparam int LHS_W  = DIST_W + Q16_W;
    localparam int GAP_W  = Q16_W + FRAC_BITS + 1;
    localparam int CMP_W  = (LHS_W > GAP_W) ? LHS_W : GAP_W;
    localparam int M_W    = DIST_W - 1;
    localparam int PROD_W = Q16_W + M_W;

    logic signed [DIST_W:0] w_diff;
    logic [DIST_W:0]        w_abs;
    t_dist                  w_max;
    t_dist                  w_mfl;
    logic [DIST_W-1:0]      r_d;
    logic [M_W-1:0]         r_m;
    logic [DIST_W-1:0]      r_d2;
    logic                   r_gap_ok;
    logic [PROD_W-1:0]      r_prod;
    logic [CMP_W-1:0]       w_lhs_cmp;
    logic [CMP_W-1:0]       w_gap_lim;
    logic [LHS_W-1:0]       w_lhs2;

    // stage a: gap magnitude and floored larger value
    always_comb begin
        w_diff = {i_a[DIST_W-1], i_a} - {i_b[DIST_W-1], i_b};
        w_abs  = w_diff[DIST_W] ? (DIST_W+1)'(-w_diff) : w_diff;
        w_max  = (i_a > i_b) ? i_a : i_b;
        w_mfl  = (w_max < FLOOR_DIST) ? FLOOR_DIST : w_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d <= w_abs[DIST_W-1:0];
            r_m <= w_mfl[M_W-1:0];
        end
    end

    // stage b: absolute gap check and ratio product
    always_comb begin
        w_lhs_cmp = CMP_W'({r_d, {Q16_W{1'b0}}});
        w_gap_lim = CMP_W'(i_gap) << FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_d2     <= r_d;
            r_gap_ok <= (w_lhs_cmp <= w_gap_lim);
            r_prod   <= PROD_W'(i_ratio) * PROD_W'(r_m);
        end
    end

    // stage c: relative gap check
    assign w_lhs2 = {r_d2, {Q16_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_ok <= r_gap_ok && (w_lhs2 <= LHS_W'(r_prod));
        end
    end

endmodule

// ----- src/gef_blend.sv -----
// ----------------------------------------------------------------------------
// gef_blend
// Two-stage weighted blend of two distances, rounded half up.
// ----------------------------------------------------------------------------
module gef_blend
    import gef_pkg::*;
(
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_dist      i_a,
    input  t_q16       i_wa,
    input  t_dist      i_b,
    input  t_q16       i_wb,
    output t_dist      o_res
);

    localparam int PROD_W = DIST_W + Q16_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pb;
    logic signed [SUM_W-1:0]  w_sum;

    // stage p: weighted products
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pa <= i_a * $signed({1'b0, i_wa});
            r_pb <= i_b * $signed({1'b0, i_wb});
        end
    end

    // stage s: sum, round and drop the weight fraction
    assign w_sum = SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(1 << (Q16_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            o_res <= w_sum[Q16_W +: DIST_W];
        end
    end

endmodule

// ----- src/gated_estimate_fusion.sv -----
// ----------------------------------------------------------------------------
// gated_estimate_fusion
// Fuses five gated distance estimates into one reference by priority rules.
// ----------------------------------------------------------------------------
// One item enters per clock cycle while the input is not stalled (o_stall low).
// The stages follow the longest chain: the first pair tests and blends,
// then the test of the two blended references against each other (diff,
// ratio multiply, compare) and the final select into the output register.
// Every stage holds its item while the output is stalled, and bubbles are
// squeezed out, so the input is only stalled when the whole pipe is full.
// No reset-time sweep: the block takes items right after reset.
module gated_estimate_fusion
    import gef_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int NSTG = 8;

    typedef struct packed {
        logic have_fr;
        logic use_sp;
        logic use_sf;
        logic use_sr;
        logic use_pf;
        logic use_pr;
        logic use_pg;
    } t_flags;

    typedef struct packed {
        logic  have_fr;
        logic  have_st;
        t_dist fr;
        t_dist st;
        t_rule fb_rule;
        t_dist fb_val;
    } t_mid;

    logic [NSTG:1] r_v;
    logic [NSTG:1] en;

    t_in_item  r_item1;
    t_flags    w1_flags;
    t_flags    r_flags2;
    t_flags    r_flags3;
    t_flags    r_flags4;
    t_dist     w3_fr;
    t_dist     w3_st;
    t_dist     w3_sf;
    t_dist     w3_sr;
    t_dist     w3_pf;
    t_dist     w3_pr;
    t_dist     w3_pg;
    t_dist     r_fr4;
    t_dist     r_st4;
    t_dist     r_sf4;
    t_dist     r_sr4;
    t_dist     r_pf4;
    t_dist     r_pr4;
    t_dist     r_pg4;
    logic      w4_ok_sp;
    logic      w4_ok_sf;
    logic      w4_ok_sr;
    logic      w4_ok_pf;
    logic      w4_ok_pr;
    logic      w4_ok_pg;
    t_mid      w4_mid;
    t_mid      r_mid5;
    t_mid      r_mid6;
    t_mid      r_mid7;
    t_dist     w6_fin;
    t_dist     r_fin7;
    logic      w7_ok_both;
    t_out_item w8_item;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        en[NSTG] = !r_v[NSTG] || !i_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[NSTG];

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: input register
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_item1 <= i_item;
        end
    end

    // usable flags of each rule
    always_comb begin
        w1_flags.have_fr = r_item1.foot_ok && r_item1.region_ok && r_item1.foot_region_agree;
        w1_flags.use_sp  = r_item1.scale_ok && r_item1.prior_ok;
        w1_flags.use_sf  = r_item1.scale_ok && r_item1.foot_ok;
        w1_flags.use_sr  = r_item1.scale_ok && r_item1.region_ok;
        w1_flags.use_pf  = r_item1.prior_ok && r_item1.foot_ok;
        w1_flags.use_pr  = r_item1.prior_ok && r_item1.region_ok;
        w1_flags.use_pg  = r_item1.prior_ok && r_item1.grounded_ok;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_flags2 <= w1_flags;
        end
        if (en[3]) begin
            r_flags3 <= r_flags2;
        end
        if (en[4]) begin
            r_flags4 <= r_flags3;
        end
    end

    // pair agreement tests, stages 2 to 4
    gef_agree u_agree_sp (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.scale_est), .i_b(r_item1.prior_est),
        .i_gap(GAP_36), .i_ratio(RATIO_16), .o_ok(w4_ok_sp)
    );
    gef_agree u_agree_sf (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.scale_est), .i_b(r_item1.foot_est),
        .i_gap(GAP_42), .i_ratio(RATIO_18), .o_ok(w4_ok_sf)
    );
    gef_agree u_agree_sr (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.scale_est), .i_b(r_item1.region_est),
        .i_gap(GAP_42), .i_ratio(RATIO_18), .o_ok(w4_ok_sr)
    );
    gef_agree u_agree_pf (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.prior_est), .i_b(r_item1.foot_est),
        .i_gap(GAP_55), .i_ratio(RATIO_22), .o_ok(w4_ok_pf)
    );
    gef_agree u_agree_pr (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.prior_est), .i_b(r_item1.region_est),
        .i_gap(GAP_55), .i_ratio(RATIO_22), .o_ok(w4_ok_pr)
    );
    gef_agree u_agree_pg (
        .i_clk(i_clk), .i_en(en[4:2]),
        .i_a(r_item1.prior_est), .i_b(r_item1.grounded_est),
        .i_gap(GAP_55), .i_ratio(RATIO_22), .o_ok(w4_ok_pg)
    );

    // pair blends, stages 2 and 3
    gef_blend u_blend_fr (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.foot_est), .i_wa(W_58),
        .i_b(r_item1.region_est), .i_wb(W_42), .o_res(w3_fr)
    );
    gef_blend u_blend_st (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.scale_est), .i_wa(W_72),
        .i_b(r_item1.prior_est), .i_wb(W_28), .o_res(w3_st)
    );
    gef_blend u_blend_sf (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.scale_est), .i_wa(W_62),
        .i_b(r_item1.foot_est), .i_wb(W_38), .o_res(w3_sf)
    );
    gef_blend u_blend_sr (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.scale_est), .i_wa(W_62),
        .i_b(r_item1.region_est), .i_wb(W_38), .o_res(w3_sr)
    );
    gef_blend u_blend_pf (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.prior_est), .i_wa(W_54),
        .i_b(r_item1.foot_est), .i_wb(W_46), .o_res(w3_pf)
    );
    gef_blend u_blend_pr (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.prior_est), .i_wa(W_54),
        .i_b(r_item1.region_est), .i_wb(W_46), .o_res(w3_pr)
    );
    gef_blend u_blend_pg (
        .i_clk(i_clk), .i_en(en[3:2]),
        .i_a(r_item1.prior_est), .i_wa(W_54),
        .i_b(r_item1.grounded_est), .i_wb(W_46), .o_res(w3_pg)
    );

    // stage 4: blends line up with the agreement flags
    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_fr4 <= w3_fr;
            r_st4 <= w3_st;
            r_sf4 <= w3_sf;
            r_sr4 <= w3_sr;
            r_pf4 <= w3_pf;
            r_pr4 <= w3_pr;
            r_pg4 <= w3_pg;
        end
    end

    // main rules and first usable fallback pair
    always_comb begin
        w4_mid.have_fr = r_flags4.have_fr;
        w4_mid.have_st = r_flags4.use_sp && w4_ok_sp;
        w4_mid.fr      = r_fr4;
        w4_mid.st      = r_st4;
        w4_mid.fb_rule = RULE_NONE;
        w4_mid.fb_val  = '0;
        if (r_flags4.use_sf && w4_ok_sf) begin
            w4_mid.fb_rule = RULE_SCALE_FOOT;
            w4_mid.fb_val  = r_sf4;
        end else if (r_flags4.use_sr && w4_ok_sr) begin
            w4_mid.fb_rule = RULE_SCALE_REG;
            w4_mid.fb_val  = r_sr4;
        end else if (r_flags4.use_pf && w4_ok_pf) begin
            w4_mid.fb_rule = RULE_PRI_FOOT;
            w4_mid.fb_val  = r_pf4;
        end else if (r_flags4.use_pr && w4_ok_pr) begin
            w4_mid.fb_rule = RULE_PRI_REG;
            w4_mid.fb_val  = r_pr4;
        end else if (r_flags4.use_pg && w4_ok_pg) begin
            w4_mid.fb_rule = RULE_PRI_GRD;
            w4_mid.fb_val  = r_pg4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_mid5 <= w4_mid;
        end
        if (en[6]) begin
            r_mid6 <= r_mid5;
        end
        if (en[7]) begin
            r_mid7 <= r_mid6;
            r_fin7 <= w6_fin;
        end
    end

    // combined references: agreement in stages 5 to 7, blend in 5 and 6
    gef_agree u_agree_both (
        .i_clk(i_clk), .i_en(en[7:5]),
        .i_a(r_st4), .i_b(r_fr4),
        .i_gap(GAP_45), .i_ratio(RATIO_18), .o_ok(w7_ok_both)
    );
    gef_blend u_blend_both (
        .i_clk(i_clk), .i_en(en[6:5]),
        .i_a(r_st4), .i_wa(W_58),
        .i_b(r_fr4), .i_wb(W_42), .o_res(w6_fin)
    );

    // stage 8: final select into the output register
    always_comb begin
        w8_item.rule_taken = r_mid7.fb_rule;
        w8_item.fused_ref  = r_mid7.fb_val;
        if (r_mid7.have_fr && r_mid7.have_st) begin
            if (w7_ok_both) begin
                w8_item.rule_taken = RULE_BOTH;
                w8_item.fused_ref  = r_fin7;
            end else begin
                w8_item.rule_taken = RULE_FOOT_REG;
                w8_item.fused_ref  = r_mid7.fr;
            end
        end else if (r_mid7.have_st) begin
            w8_item.rule_taken = RULE_SCALE_PRI;
            w8_item.fused_ref  = r_mid7.st;
        end else if (r_mid7.have_fr) begin
            w8_item.rule_taken = RULE_FOOT_REG;
            w8_item.fused_ref  = r_mid7.fr;
        end
        w8_item.fused_ok = (w8_item.rule_taken != RULE_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            o_item <= w8_item;
        end
    end

endmodule

// ----- src/gef_checker.sv -----
// ----------------------------------------------------------------------------
// gef_checker
// Port-level checks on the fused result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gef_checker
    import gef_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // no item may leave in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_item)))
        else $error("stalled result changed");

    // ok flag matches the rule number
    a_ok_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.fused_ok == (o_item.rule_taken != RULE_NONE)))
        else $error("fused_ok disagrees with rule_taken");

    // no rule gives a zero reference
    a_zero_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.fused_ok) |-> (o_item.fused_ref == '0))
        else $error("reference not zero without a rule");

    // rule number within the defined set
    a_rule_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.rule_taken <= RULE_LAST))
        else $error("rule_taken out of range");

endmodule

bind gated_estimate_fusion gef_checker u_gef_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);
